// ===== design/lpkt_pkg.sv =====
`default_nettype none

package lpkt_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_MAX_KEY_LEN = 32;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 3;
  localparam int SLOT_OUT_W = 4;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [CODE_W-1:0] RC_ADDED    = 3'd0;
  localparam logic [CODE_W-1:0] RC_FULL     = 3'd1;
  localparam logic [CODE_W-1:0] RC_TOGGLED  = 3'd2;
  localparam logic [CODE_W-1:0] RC_QUERIED  = 3'd3;
  localparam logic [CODE_W-1:0] RC_MISSING  = 3'd4;
  localparam logic [CODE_W-1:0] RC_TOO_LONG = 3'd5;

endpackage

`default_nettype wire

// ===== design/linear_probe_key_table_core.sv =====
`default_nettype none

// A byte without the last mark is collected while the block stays idle. A last byte moves
// the block through S_DECIDE, then through S_RD_META and S_CHK_META for each probed slot,
// S_CMP_RD and S_CMP_CHK for each compared key byte, and S_COPY_RD and S_COPY_WR for each
// byte copied on an add. After reset the block stays busy while it clears the slot memory.
// The result strobe done is high for one cycle and cannot be held off by the receiver.
module linear_probe_key_table_core #(
  parameter int TABLE_SLOTS = lpkt_pkg::DEF_TABLE_SLOTS,
  parameter int MAX_KEY_LEN = lpkt_pkg::DEF_MAX_KEY_LEN
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [lpkt_pkg::CMD_W-1:0]    cmd,
  input  wire logic [lpkt_pkg::BYTE_W-1:0]   key_byte,
  input  wire logic                          key_last,
  output logic                               done,
  output logic      [lpkt_pkg::CODE_W-1:0]   result_code,
  output logic                               flag_on,
  output logic      [lpkt_pkg::SLOT_OUT_W-1:0] slot_index
);
  import lpkt_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int NW = $clog2(MAX_KEY_LEN + 1);
  localparam int LW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECIDE   = 4'd2;
  localparam logic [3:0] S_RD_META  = 4'd3;
  localparam logic [3:0] S_CHK_META = 4'd4;
  localparam logic [3:0] S_CMP_RD   = 4'd5;
  localparam logic [3:0] S_CMP_CHK  = 4'd6;
  localparam logic [3:0] S_COPY_RD  = 4'd7;
  localparam logic [3:0] S_COPY_WR  = 4'd8;

  logic [3:0]        state, state_next;
  logic [SW-1:0]     cur, cur_next;
  logic [SW-1:0]     start_slot, start_slot_next;
  logic [LW-1:0]     idx, idx_next;
  logic [CMD_W-1:0]  cmd_q, cmd_q_next;

  logic              take;
  logic [NW-1:0]     coll_len;
  logic [SW-1:0]     coll_sum;
  logic              coll_ovf;
  logic              coll_we;
  logic [LW-1:0]     coll_waddr;

  logic              m_we, m_wused, m_wflag, m_re;
  logic [SW-1:0]     m_waddr, m_raddr;
  logic [NW-1:0]     m_wlen;
  logic              m_used, m_flag;
  logic [NW-1:0]     m_len;

  logic              inc_re, key_re, key_we;
  logic [LW-1:0]     inc_raddr;
  logic [SW+LW-1:0]  key_addr;
  logic [BYTE_W-1:0] inc_rdata, key_rdata;

  logic              fin;
  logic [CODE_W-1:0] fin_code;
  logic              fin_flag;
  logic [SW-1:0]     fin_slot;
  logic [SW-1:0]     nxt;
  logic              wrap, last_idx, is_add, is_toggle;

  assign busy      = (state != S_IDLE);
  assign take      = start && !busy;
  assign nxt       = (cur == SW'(TABLE_SLOTS - 1)) ? '0 : cur + 1'b1;
  assign wrap      = (nxt == start_slot);
  assign last_idx  = (NW'(idx) == coll_len - 1'b1);
  assign is_add    = (cmd_q == CMD_ADD);
  assign is_toggle = (cmd_q == CMD_TOGGLE);
  assign key_addr  = {cur, idx};
  assign inc_raddr = idx;

  lpkt_collector #(
    .TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_LEN(MAX_KEY_LEN), .SW(SW), .NW(NW), .LW(LW)
  ) u_coll (
    .clk(clk), .rst(rst), .take(take), .clear(fin), .key_byte(key_byte),
    .len(coll_len), .sum(coll_sum), .ovf(coll_ovf), .wr_en(coll_we), .wr_addr(coll_waddr)
  );

  lpkt_byte_ram #(.DEPTH(MAX_KEY_LEN), .AW(LW)) u_inc_ram (
    .clk(clk), .we(coll_we), .waddr(coll_waddr), .wdata(key_byte),
    .re(inc_re), .raddr(inc_raddr), .rdata(inc_rdata)
  );

  lpkt_byte_ram #(.DEPTH(TABLE_SLOTS << LW), .AW(SW + LW)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_addr), .wdata(inc_rdata),
    .re(key_re), .raddr(key_addr), .rdata(key_rdata)
  );

  lpkt_meta_ram #(.TABLE_SLOTS(TABLE_SLOTS), .SW(SW), .NW(NW)) u_meta_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wused(m_wused), .wflag(m_wflag),
    .wlen(m_wlen), .re(m_re), .raddr(m_raddr), .rused(m_used), .rflag(m_flag),
    .rlen(m_len)
  );

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    start_slot_next = start_slot;
    idx_next        = idx;
    cmd_q_next      = cmd_q;
    m_we            = 1'b0;
    m_waddr         = cur;
    m_wused         = 1'b1;
    m_wflag         = m_flag;
    m_wlen          = coll_len;
    m_re            = 1'b0;
    m_raddr         = cur;
    inc_re          = 1'b0;
    key_re          = 1'b0;
    key_we          = 1'b0;
    fin             = 1'b0;
    fin_code        = RC_MISSING;
    fin_flag        = 1'b0;
    fin_slot        = '0;

    unique case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_wused = 1'b0;
        m_wflag = 1'b0;
        m_wlen  = '0;
        cur_next = nxt;
        if (cur == SW'(TABLE_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take && key_last) begin
          cmd_q_next = cmd;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (coll_ovf) begin
          fin        = 1'b1;
          fin_code   = RC_TOO_LONG;
          state_next = S_IDLE;
        end else begin
          cur_next        = coll_sum;
          start_slot_next = coll_sum;
          state_next      = S_RD_META;
        end
      end
      S_RD_META: begin
        m_re       = 1'b1;
        state_next = S_CHK_META;
      end
      S_CHK_META: begin
        idx_next = '0;
        if (is_add) begin
          if (!m_used) begin
            m_we       = 1'b1;
            state_next = S_COPY_RD;
          end else if (wrap) begin
            fin        = 1'b1;
            fin_code   = RC_FULL;
            state_next = S_IDLE;
          end else begin
            cur_next   = nxt;
            state_next = S_RD_META;
          end
        end else if (!m_used) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (m_len == coll_len) begin
          state_next = S_CMP_RD;
        end else if (wrap) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_next   = nxt;
          state_next = S_RD_META;
        end
      end
      S_CMP_RD: begin
        inc_re     = 1'b1;
        key_re     = 1'b1;
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (key_rdata != inc_rdata) begin
          if (wrap) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end else begin
            cur_next   = nxt;
            state_next = S_RD_META;
          end
        end else if (last_idx) begin
          fin        = 1'b1;
          fin_slot   = cur;
          state_next = S_IDLE;
          if (is_toggle) begin
            m_we     = 1'b1;
            m_wflag  = !m_flag;
            m_wlen   = m_len;
            fin_code = RC_TOGGLED;
            fin_flag = !m_flag;
          end else begin
            fin_code = RC_QUERIED;
            fin_flag = m_flag;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_CMP_RD;
        end
      end
      S_COPY_RD: begin
        inc_re     = 1'b1;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        key_we = 1'b1;
        if (last_idx) begin
          fin        = 1'b1;
          fin_code   = RC_ADDED;
          fin_slot   = cur;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_COPY_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    start_slot <= start_slot_next;
    idx        <= idx_next;
    cmd_q      <= cmd_q_next;
    if (fin) begin
      result_code <= fin_code;
      flag_on     <= fin_flag;
      slot_index  <= SLOT_OUT_W'(fin_slot);
    end
  end

endmodule

`default_nettype wire

// ===== design/lpkt_byte_ram.sv =====
`default_nettype none

module lpkt_byte_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [lpkt_pkg::BYTE_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output logic      [lpkt_pkg::BYTE_W-1:0] rdata
);
  import lpkt_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lpkt_meta_ram.sv =====
`default_nettype none

module lpkt_meta_ram #(
  parameter int TABLE_SLOTS = 16,
  parameter int SW          = 4,
  parameter int NW          = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [SW-1:0] waddr,
  input  wire logic          wused,
  input  wire logic          wflag,
  input  wire logic [NW-1:0] wlen,
  input  wire logic          re,
  input  wire logic [SW-1:0] raddr,
  output logic               rused,
  output logic               rflag,
  output logic      [NW-1:0] rlen
);
  import lpkt_pkg::*;

  logic [NW+1:0] mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wused, wflag, wlen};
    end
    if (re) begin
      {rused, rflag, rlen} <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lpkt_collector.sv =====
`default_nettype none

module lpkt_collector #(
  parameter int TABLE_SLOTS = 16,
  parameter int MAX_KEY_LEN = 32,
  parameter int SW          = 4,
  parameter int NW          = 6,
  parameter int LW          = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic                        clear,
  input  wire logic [lpkt_pkg::BYTE_W-1:0] key_byte,
  output logic      [NW-1:0]               len,
  output logic      [SW-1:0]               sum,
  output logic                             ovf,
  output logic                             wr_en,
  output logic      [LW-1:0]               wr_addr
);
  import lpkt_pkg::*;

  logic [17:0]   red;
  logic [SW:0]   sum_ext;
  logic [SW-1:0] sum_next;
  logic          room;

  // The byte is reduced by restoring subtraction of shifted table sizes.
  always_comb begin
    red = 18'(key_byte);
    for (int k = 7; k >= 0; k--) begin
      if (red >= (18'(TABLE_SLOTS) << k)) begin
        red = red - (18'(TABLE_SLOTS) << k);
      end
    end
    sum_ext = {1'b0, sum} + {1'b0, SW'(red)};
    if (sum_ext >= (SW+1)'(TABLE_SLOTS)) begin
      sum_ext = sum_ext - (SW+1)'(TABLE_SLOTS);
    end
    sum_next = SW'(sum_ext);
  end

  assign room    = len < NW'(MAX_KEY_LEN);
  assign wr_en   = take && room;
  assign wr_addr = LW'(len);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      len <= '0;
      sum <= '0;
      ovf <= 1'b0;
    end else if (take) begin
      if (room) begin
        len <= len + 1'b1;
        sum <= sum_next;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  import lpkt_pkg::*;

  localparam int SLOTS = DEF_TABLE_SLOTS;
  localparam int KEY_MAX = DEF_MAX_KEY_LEN;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_KEYS = 10;
  localparam int RANDOM_BEATS = 1900;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1200;

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic                  flag;
    logic [SLOT_OUT_W-1:0] slot;
  } outcome_t;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] kb;
    bit                last;
    int                reps;
    bit                pinned;
    outcome_t          want;
  } stim_row_t;

  localparam outcome_t NO_PIN = '{RC_MISSING, 1'b0, 4'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CMD_W-1:0] cmd = '0;
  logic [BYTE_W-1:0] key_byte = '0;
  logic key_last = 1'b0;
  logic busy;
  logic done;
  logic [CODE_W-1:0] result_code;
  logic flag_on;
  logic [SLOT_OUT_W-1:0] slot_index;

  // Typed expectation that travels with the beat currently on the inputs.
  bit pinned = 1'b0;
  outcome_t pinned_outcome = NO_PIN;

  outcome_t awaited_results[$];
  int failures = 0;
  int idle_cycles = 0;
  int beats_sent = 0;
  bit calm = 1'b0;

  // Shadow of the table and of the key being collected.
  bit shadow_used[SLOTS];
  bit shadow_flag[SLOTS];
  logic [BYTE_W-1:0] shadow_keys[SLOTS][KEY_MAX];
  int shadow_len[SLOTS];
  logic [BYTE_W-1:0] gather_key[KEY_MAX];
  int gather_len = 0;
  int gather_sum = 0;
  bit gather_over = 1'b0;

  logic [BYTE_W-1:0] key_buf[48];
  logic [BYTE_W-1:0] pool_bytes[POOL_KEYS][6];
  int pool_len[POOL_KEYS];

  stim_row_t directed_rows[16] = '{
    '{CMD_QUERY,  8'h41, 1'b1, 1,  1'b1, '{RC_MISSING, 1'b0, 4'd0}},
    '{CMD_ADD,    8'h41, 1'b1, 1,  1'b1, '{RC_ADDED, 1'b0, 4'd1}},
    '{CMD_TOGGLE, 8'h41, 1'b1, 1,  1'b1, '{RC_TOGGLED, 1'b1, 4'd1}},
    '{CMD_UNUSED, 8'h41, 1'b1, 1,  1'b1, '{RC_QUERIED, 1'b1, 4'd1}},
    '{CMD_ADD,    8'hFF, 1'b1, 1,  1'b1, '{RC_ADDED, 1'b0, 4'd15}},
    '{CMD_ADD,    8'h0F, 1'b1, 1,  1'b0, NO_PIN},
    '{CMD_QUERY,  8'h0F, 1'b1, 1,  1'b0, NO_PIN},
    '{CMD_TOGGLE, 8'h00, 1'b0, 1,  1'b0, NO_PIN},
    '{CMD_ADD,    8'h01, 1'b1, 1,  1'b0, NO_PIN},
    '{CMD_TOGGLE, 8'h01, 1'b1, 1,  1'b0, NO_PIN},
    '{CMD_QUERY,  8'h00, 1'b0, 1,  1'b0, NO_PIN},
    '{CMD_TOGGLE, 8'h01, 1'b1, 1,  1'b0, NO_PIN},
    '{CMD_ADD,    8'h41, 1'b1, 1,  1'b0, NO_PIN},
    '{CMD_ADD,    8'h80, 1'b0, 32, 1'b0, NO_PIN},
    '{CMD_ADD,    8'h80, 1'b1, 1,  1'b1, '{RC_TOO_LONG, 1'b0, 4'd0}},
    '{CMD_QUERY,  8'h41, 1'b1, 1,  1'b0, NO_PIN}
  };

  linear_probe_key_table_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .key_byte    (key_byte),
    .key_last    (key_last),
    .done        (done),
    .result_code (result_code),
    .flag_on     (flag_on),
    .slot_index  (slot_index)
  );

  always #5 clk = ~clk;

  task automatic probe_table_step(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] kb,
                                  input bit last, output bit has_result,
                                  output outcome_t res);
    int first;
    int s;
    bit full;
    bit found;
    bit same;
    has_result = 1'b0;
    res = NO_PIN;
    if (gather_len < KEY_MAX) begin
      gather_key[gather_len] = kb;
      gather_len++;
      gather_sum = (gather_sum + kb) % SLOTS;
    end else begin
      gather_over = 1'b1;
    end
    if (last) begin
      has_result = 1'b1;
      first = gather_sum;
      s = first;
      if (gather_over) begin
        res.code = RC_TOO_LONG;
      end else if (op == CMD_ADD) begin
        full = 1'b0;
        while (shadow_used[s] && !full) begin
          s = (s + 1) % SLOTS;
          if (s == first) full = 1'b1;
        end
        if (full) begin
          res.code = RC_FULL;
        end else begin
          shadow_used[s] = 1'b1;
          shadow_len[s] = gather_len;
          for (int i = 0; i < gather_len; i++) shadow_keys[s][i] = gather_key[i];
          res.code = RC_ADDED;
          res.slot = s[SLOT_OUT_W-1:0];
        end
      end else begin
        found = 1'b0;
        full = 1'b0;
        while (shadow_used[s] && !found && !full) begin
          same = (shadow_len[s] == gather_len);
          for (int i = 0; i < gather_len && same; i++)
            if (shadow_keys[s][i] != gather_key[i]) same = 1'b0;
          if (same) begin
            found = 1'b1;
          end else begin
            s = (s + 1) % SLOTS;
            if (s == first) full = 1'b1;
          end
        end
        if (found) begin
          if (op == CMD_TOGGLE) begin
            shadow_flag[s] = !shadow_flag[s];
            res.code = RC_TOGGLED;
          end else begin
            res.code = RC_QUERIED;
          end
          res.flag = shadow_flag[s];
          res.slot = s[SLOT_OUT_W-1:0];
        end
      end
      gather_len = 0;
      gather_sum = 0;
      gather_over = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    if ($urandom_range(0, 19) == 0) return 8'h00;
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] kb,
                           input bit last, input bit pin, input outcome_t pin_val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    key_byte <= kb;
    key_last <= last;
    pinned <= pin;
    pinned_outcome <= pin_val;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_key(input logic [CMD_W-1:0] op, input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_beat(op, key_buf[i], 1'b1, 1'b0, NO_PIN);
      else send_beat(CMD_W'($urandom_range(0, 3)), key_buf[i], 1'b0, 1'b0, NO_PIN);
    end
  endtask

  always @(posedge clk) begin : monitor
    bit has_result;
    outcome_t predicted;
    outcome_t want;
    bit progress;
    if (!rst) begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: result_code %0d flag_on %0d slot_index %0d",
                 result_code, flag_on, slot_index);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (result_code !== want.code) begin
            $error("result_code: expected %0d, actual %0d", want.code, result_code);
            failures++;
          end
          if (flag_on !== want.flag) begin
            $error("flag_on: expected %0d, actual %0d", want.flag, flag_on);
            failures++;
          end
          if (slot_index !== want.slot) begin
            $error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
            failures++;
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        probe_table_step(cmd, key_byte, key_last, has_result, predicted);
        if (has_result) awaited_results.push_back(pinned ? pinned_outcome : predicted);
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("linear_probe_key_table_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int n;
    int p;
    logic [CMD_W-1:0] op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_beat(directed_rows[i].op, directed_rows[i].kb, directed_rows[i].last,
                  directed_rows[i].pinned, directed_rows[i].want);
    end
    drain_results();

    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_len[i] = $urandom_range(1, 6);
      for (int j = 0; j < 6; j++) pool_bytes[i][j] = random_byte();
    end

    // Mostly keys from a small pool so that toggles and queries find their
    // entries; fresh keys, maximum-length and overlong keys mixed in.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 15) op = CMD_ADD;
      else if (r < 55) op = CMD_TOGGLE;
      else if (r < 95) op = CMD_QUERY;
      else op = CMD_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        p = $urandom_range(0, POOL_KEYS - 1);
        n = pool_len[p];
        for (int j = 0; j < n; j++) key_buf[j] = pool_bytes[p][j];
      end else begin
        if (r < 91) n = $urandom_range(1, 6);
        else if (r < 95) n = KEY_MAX;
        else n = $urandom_range(KEY_MAX + 1, 40);
        for (int j = 0; j < n; j++) key_buf[j] = random_byte();
      end
      send_key(op, n);
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("linear_probe_key_table_core: match");
    end else begin
      $display("linear_probe_key_table_core: mismatch");
    end
    $finish;
  end

endmodule
